>>> rtl/svl_pkg.sv
// Package for the servo slew limiter: payload types, register indexes and constants.
`timescale 1ns / 1ps

package svl_pkg;

    localparam int FRAC_BITS_DEF = 8;

    localparam int ANGLE_W   = 8;
    localparam int SPEED_W   = 10;
    localparam int TIME_W    = 32;
    localparam int PULSE_W   = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 10;

    localparam logic [ANGLE_W-1:0] ANGLE_FULL = 8'd180;
    localparam logic [ANGLE_W-1:0] ANGLE_MID  = 8'd90;
    localparam logic [SPEED_W-1:0] SPEED_RST  = 10'd180;
    localparam logic [PULSE_W-1:0] PULSE_MIN  = 12'd600;
    localparam logic [10:0]        MS_PER_S   = 11'd1000;

    // pulse span is a*1900/180 = floor(a*95/9); 1/9 taken as 58255 / 2^19
    localparam logic [6:0]  SPAN_NUM   = 7'd95;
    localparam logic [15:0] RECIP_NINE = 16'd58255;
    localparam int          RECIP_SH   = 19;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_ANGLE  = 2'd0,
        CFG_MAX_ANGLE  = 2'd1,
        CFG_SLEW_SPEED = 2'd2,
        CFG_REVERSE    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic               func;
        logic [ANGLE_W-1:0] target_angle;
        logic [TIME_W-1:0]  now_ms;
    } t_in;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle_out;
        logic [PULSE_W-1:0] pulse_us;
    } t_out;

endpackage

>>> rtl/servo_slew_limited_pulse.sv
// Servo slew-rate limiter: clamps the goal, steps the angle by a bit-serial divide, forms the pulse.
//
// Input channel (i_in_valid / o_in_stall, payload i_in): func 1 stores a new goal
// angle, func 0 is a tick carrying the millisecond time. Every request yields one
// result on the output channel (o_out_valid / i_out_stall, payload o_out): the
// integer angle and the pulse width in microseconds.
// Configuration writes (i_cfg_valid / o_cfg_ready) take i_cfg_index 0..3 for
// min angle, max angle, slew speed and reverse; o_cfg_ready is always high.
// One request is worked on at a time. A set request passes through the pulse and
// output states; a tick whose goal is already reached goes from the multiply state
// to those two, and a moving tick runs the multiply, divide and update states first:
// the step speed*elapsed*2^FRAC_BITS/1000 comes out of a restoring divider that
// takes one dividend bit per cycle over its 42 + FRAC_BITS dividend bits.
// The output register holds a finished result while the receiver stalls; the
// next request is still taken, and its result waits in the last stage until the
// output register frees up.
// Synchronous reset puts the angle and goal at 90 degrees, the tick time at zero
// and the registers at their defaults (0, 180, 180 deg/s, not reversed).
`timescale 1ns / 1ps

module servo_slew_limited_pulse #(
    parameter int FRAC_BITS = svl_pkg::FRAC_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_stall,
    input  svl_pkg::t_in                             i_in,
    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output svl_pkg::t_out                            o_out,
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [svl_pkg::CFG_IDX_W-1:0]            i_cfg_index,
    input  logic [svl_pkg::CFG_DAT_W-1:0]            i_cfg_data
);

    localparam int AW    = svl_pkg::ANGLE_W;
    localparam int CW    = AW + FRAC_BITS;          // current angle, fixed point
    localparam int QW    = CW + 1;                  // quotient, one guard bit
    localparam int XW    = svl_pkg::SPEED_W + svl_pkg::TIME_W;
    localparam int NBITS = XW + FRAC_BITS;          // dividend bits
    localparam int CNTW  = $clog2(NBITS);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_DIV   = 6'b000100,
        S_UPD   = 6'b001000,
        S_PULSE = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [AW-1:0]                   r_min, r_max;
    logic [svl_pkg::SPEED_W-1:0]     r_speed;
    logic                            r_rev;

    logic [AW-1:0]                   r_goal, n_goal;
    logic [CW-1:0]                   r_cur, n_cur;
    logic [svl_pkg::TIME_W-1:0]      r_last, n_last;
    logic [svl_pkg::TIME_W-1:0]      r_elapsed, n_elapsed;

    logic [NBITS-1:0]                r_x, n_x;
    logic [9:0]                      r_rem, n_rem;
    logic [QW-1:0]                   r_q, n_q;
    logic                            r_sat, n_sat;
    logic [CNTW-1:0]                 r_cnt, n_cnt;
    logic [CW-1:0]                   r_diff, n_diff;
    logic                            r_up, n_up;

    logic [AW-1:0]                   r_a, n_a;
    logic [14:0]                     r_m95, n_m95;

    logic                            r_out_valid, n_out_valid;
    svl_pkg::t_out                   r_out, n_out;

    logic [AW-1:0]                   hi, lo, goal_clamped;
    logic [CW-1:0]                   goal_fx;
    logic [10:0]                     trial;
    logic                            qbit;
    logic [AW-1:0]                   a_int, m_ang;
    logic [30:0]                     span_prod;
    logic                            in_acc, out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        hi = (r_max > svl_pkg::ANGLE_FULL) ? svl_pkg::ANGLE_FULL : r_max;
        lo = (r_min > svl_pkg::ANGLE_FULL) ? svl_pkg::ANGLE_FULL : r_min;
        if (r_goal > hi) begin
            goal_clamped = hi;
        end else if (r_goal < lo) begin
            goal_clamped = lo;
        end else begin
            goal_clamped = r_goal;
        end
        goal_fx   = CW'(r_goal) << FRAC_BITS;
        trial     = {r_rem, r_x[NBITS-1]};
        qbit      = (trial >= svl_pkg::MS_PER_S);
        a_int     = AW'(r_cur >> FRAC_BITS);
        if (a_int > svl_pkg::ANGLE_FULL) begin
            a_int = svl_pkg::ANGLE_FULL;
        end
        m_ang     = r_rev ? (svl_pkg::ANGLE_FULL - a_int) : a_int;
        span_prod = 31'(r_m95) * 31'(svl_pkg::RECIP_NINE);
    end

    always_comb begin
        n_state     = r_state;
        n_goal      = r_goal;
        n_cur       = r_cur;
        n_last      = r_last;
        n_elapsed   = r_elapsed;
        n_x         = r_x;
        n_rem       = r_rem;
        n_q         = r_q;
        n_sat       = r_sat;
        n_cnt       = r_cnt;
        n_diff      = r_diff;
        n_up        = r_up;
        n_a         = r_a;
        n_m95       = r_m95;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.func) begin
                        n_goal  = i_in.target_angle;
                        n_state = S_PULSE;
                    end else begin
                        n_goal    = goal_clamped;
                        n_elapsed = i_in.now_ms - r_last;
                        n_last    = i_in.now_ms;
                        n_state   = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_x   = NBITS'(XW'(r_speed) * XW'(r_elapsed)) << FRAC_BITS;
                n_rem = '0;
                n_q   = '0;
                n_sat = 1'b0;
                n_cnt = CNTW'(NBITS - 1);
                n_up  = (goal_fx > r_cur);
                n_diff = (goal_fx > r_cur) ? (goal_fx - r_cur) : (r_cur - goal_fx);
                n_state = (goal_fx == r_cur) ? S_PULSE : S_DIV;
            end
            S_DIV: begin
                // one dividend bit per cycle, remainder stays below 1000
                n_rem = qbit ? 10'(trial - svl_pkg::MS_PER_S) : trial[9:0];
                n_x   = r_x << 1;
                n_sat = r_sat | r_q[QW-1];
                n_q   = {r_q[QW-2:0], qbit};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                // stop at the goal when the step reaches it
                if (r_sat || (r_q >= {1'b0, r_diff})) begin
                    n_cur = goal_fx;
                end else if (r_up) begin
                    n_cur = r_cur + r_q[CW-1:0];
                end else begin
                    n_cur = r_cur - r_q[CW-1:0];
                end
                n_state = S_PULSE;
            end
            S_PULSE: begin
                n_a     = a_int;
                n_m95   = 15'(m_ang) * 15'(svl_pkg::SPAN_NUM);
                n_state = S_OUT;
            end
            S_OUT: begin
                // hold until the output register frees up
                if (out_free) begin
                    n_out.angle_out = r_a;
                    n_out.pulse_us  = svl_pkg::PULSE_MIN
                                      + svl_pkg::PULSE_W'(span_prod >> svl_pkg::RECIP_SH);
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_min       <= '0;
            r_max       <= svl_pkg::ANGLE_FULL;
            r_speed     <= svl_pkg::SPEED_RST;
            r_rev       <= 1'b0;
            r_goal      <= svl_pkg::ANGLE_MID;
            r_cur       <= CW'(svl_pkg::ANGLE_MID) << FRAC_BITS;
            r_last      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_goal      <= n_goal;
            r_cur       <= n_cur;
            r_last      <= n_last;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    svl_pkg::CFG_MIN_ANGLE:  r_min   <= i_cfg_data[AW-1:0];
                    svl_pkg::CFG_MAX_ANGLE:  r_max   <= i_cfg_data[AW-1:0];
                    svl_pkg::CFG_SLEW_SPEED: r_speed <= i_cfg_data[svl_pkg::SPEED_W-1:0];
                    svl_pkg::CFG_REVERSE:    r_rev   <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_elapsed <= n_elapsed;
        r_x       <= n_x;
        r_rem     <= n_rem;
        r_q       <= n_q;
        r_sat     <= n_sat;
        r_cnt     <= n_cnt;
        r_diff    <= n_diff;
        r_up      <= n_up;
        r_a       <= n_a;
        r_m95     <= n_m95;
        r_out     <= n_out;
    end

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur >> FRAC_BITS) <= CW'(svl_pkg::ANGLE_FULL))
        else $error("current angle above full scale");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |=> (r_rem < svl_pkg::MS_PER_S[9:0]))
        else $error("divider remainder out of range");

    a_out_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("result shown outside the output stage");

    a_out_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> (o_out_valid && r_state == S_IDLE))
        else $error("finished result not moved to output");

endmodule
